// ===== hw/rtl/ght_pkg.sv =====
`timescale 1ns / 1ps

package ght_pkg;

  localparam int KEY_W  = 32;
  localparam int PGEN_W = 16;
  localparam int GEN_W  = 9;
  localparam int SLOT_W = 7;
  localparam int TOK_W  = GEN_W + SLOT_W;
  localparam int REQ_W  = 3;

  localparam logic [GEN_W-1:0] GEN_MAX = 9'h1FF;

  localparam logic [REQ_W-1:0] REQ_FIND    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESOLVE = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PGEN_W-1:0] pgen;
    logic [GEN_W-1:0]  gen;
  } slot_word_t;

  // one slot as seen by the sequencer, in the cycle after its address was issued
  typedef struct packed {
    slot_word_t word;
    logic       active;
    logic       retired;
  } slot_rd_t;

  typedef struct packed {
    logic              mem_en;
    logic              set_act;
    logic              clr_act;
    logic              set_ret;
    logic [SLOT_W-1:0] addr;
    slot_word_t        word;
  } slot_wr_t;

  function automatic logic [TOK_W-1:0] make_token(input logic [SLOT_W-1:0] slot,
                                                  input logic [GEN_W-1:0]  gen);
    return {gen, slot + 7'd1};
  endfunction

endpackage

// ===== hw/rtl/ght_slot_store.sv =====
`timescale 1ns / 1ps

module ght_slot_store import ght_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SLOT_W-1:0]    rd_addr,
  output slot_rd_t             rd_q,
  input  slot_wr_t             wr
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  slot_word_t             mem [SLOT_COUNT];
  slot_word_t             rd_word_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [SLOT_COUNT-1:0]  act_r;
  logic [SLOT_COUNT-1:0]  ret_r;
  logic [SLOT_COUNT-1:0]  gvld_r;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       rd_idx;

  assign wr_idx = wr.addr[IDX_W-1:0];
  assign rd_idx = rd_addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.mem_en) begin
      mem[wr_idx] <= wr.word;
    end
    rd_word_r <= mem[rd_idx];
    rd_idx_r  <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      ret_r  <= '0;
      gvld_r <= '0;
    end else begin
      if (wr.set_act) begin
        act_r[wr_idx] <= 1'b1;
      end
      if (wr.clr_act) begin
        act_r[wr_idx] <= 1'b0;
      end
      if (wr.set_ret) begin
        ret_r[wr_idx] <= 1'b1;
      end
      if (wr.mem_en) begin
        gvld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // a slot never written since reset has generation zero
  always_comb begin
    rd_q.word.key  = rd_word_r.key;
    rd_q.word.pgen = rd_word_r.pgen;
    rd_q.word.gen  = gvld_r[rd_idx_r] ? rd_word_r.gen : '0;
    rd_q.active    = act_r[rd_idx_r];
    rd_q.retired   = ret_r[rd_idx_r];
  end

endmodule

// ===== hw/rtl/generational_handle_table_unit.sv =====
`timescale 1ns / 1ps
// Generational handle table. Binds 32-bit source keys to 16-bit tokens
// (generation in bits 15..7, slot plus one in bits 6..0).
// Requests: find, acquire, release, check token, resolve token. A request is
// accepted on a rising edge with start high and busy low; busy stays high
// while the request is worked on. Each request gives exactly one result,
// shown on the out_ ports for one cycle with out_valid high; the receiver
// takes it at the edge ending that cycle and cannot hold it off.
// Key requests scan the slot RAM one slot per cycle through its single
// registered read port; acquire of a new key scans a second time. Check
// and resolve read one slot. A request rejected up front (zero key, bad
// slot field, unknown type) strobes the cycle after accept.
// A new request may be accepted in the cycle its predecessor's result shows.
// Reset clears all slots at once (active, retired and generation-valid
// flags); no clearing pass is needed.
module generational_handle_table_unit import ght_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [KEY_W-1:0]  in_source_key,
  input  logic [PGEN_W-1:0] in_package_gen,
  input  logic [TOK_W-1:0]  in_token_in,
  output logic              out_valid,
  output logic              out_ok,
  output logic [TOK_W-1:0]  out_token_out,
  output logic [GEN_W-1:0]  out_generation_out,
  output logic [KEY_W-1:0]  out_resolved_key
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LIM  = SLOT_W'(SLOT_COUNT);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_ALLOC  = 2'd2;
  localparam logic [1:0] S_TOKEN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [PGEN_W-1:0] pgen_r, pgen_nxt;
  logic [GEN_W-1:0]  tgen_r, tgen_nxt;
  logic              issue_r, issue_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic              pipe_vld_r, pipe_vld_nxt;
  logic [IDX_W-1:0]  pipe_idx_r, pipe_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [TOK_W-1:0]  out_tok_r, out_tok_nxt;
  logic [GEN_W-1:0]  out_gen_r, out_gen_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;

  slot_rd_t          rd_q;
  slot_wr_t          wr;
  logic [SLOT_W-1:0] pipe_slot;
  logic [SLOT_W-1:0] scan_slot;
  logic [SLOT_W-1:0] in_enc;

  assign pipe_slot = SLOT_W'(pipe_idx_r);
  assign scan_slot = SLOT_W'(scan_r);
  assign in_enc    = in_token_in[SLOT_W-1:0];

  ght_slot_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(scan_slot),
    .rd_q   (rd_q),
    .wr     (wr)
  );

  always_comb begin
    logic             fin;
    logic             hit;
    logic             tok_ok;
    logic [GEN_W-1:0] gen_inc;

    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    pgen_nxt      = pgen_r;
    tgen_nxt      = tgen_r;
    issue_nxt     = issue_r;
    scan_nxt      = scan_r;
    pipe_vld_nxt  = 1'b0;
    pipe_idx_nxt  = pipe_idx_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    out_tok_nxt   = '0;
    out_gen_nxt   = '0;
    out_key_nxt   = '0;
    wr            = '0;
    wr.addr       = pipe_slot;
    fin           = 1'b0;
    hit           = rd_q.active && (rd_q.word.key == key_r);
    tok_ok        = rd_q.active && (rd_q.word.gen == tgen_r) && (tgen_r != '0);
    gen_inc       = rd_q.word.gen + 9'd1;

    // read pipeline: the address issued now comes back next cycle
    if (issue_r) begin
      pipe_vld_nxt = 1'b1;
      pipe_idx_nxt = scan_r;
      if (scan_r == LAST_IDX || state_r == S_TOKEN) begin
        issue_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + IDX_W'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_req_type;
          key_nxt  = in_source_key;
          pgen_nxt = in_package_gen;
          tgen_nxt = in_token_in[TOK_W-1:SLOT_W];
          case (in_req_type) inside
            REQ_FIND, REQ_ACQUIRE, REQ_RELEASE: begin
              if (in_source_key == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_LOOKUP;
                scan_nxt  = '0;
                issue_nxt = 1'b1;
              end
            end
            REQ_CHECK, REQ_RESOLVE: begin
              if (in_enc == '0 || in_enc > SLOT_LIM) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_TOKEN;
                scan_nxt  = IDX_W'(in_enc - 7'd1);
                issue_nxt = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      S_LOOKUP: begin
        if (pipe_vld_r) begin
          if (hit) begin
            fin = 1'b1;
            case (req_r)
              REQ_FIND: begin
                out_ok_nxt  = 1'b1;
                out_tok_nxt = make_token(pipe_slot, rd_q.word.gen);
              end
              REQ_ACQUIRE: begin
                if (rd_q.word.pgen == pgen_r) begin
                  out_ok_nxt  = 1'b1;
                  out_tok_nxt = make_token(pipe_slot, rd_q.word.gen);
                end
              end
              default: begin
                // release keeps the generation, clears key and package gen
                wr.mem_en   = 1'b1;
                wr.clr_act  = 1'b1;
                wr.word.gen = rd_q.word.gen;
                out_ok_nxt  = 1'b1;
              end
            endcase
          end else if (pipe_idx_r == LAST_IDX) begin
            if (req_r == REQ_ACQUIRE) begin
              state_nxt    = S_ALLOC;
              scan_nxt     = '0;
              issue_nxt    = 1'b1;
              pipe_vld_nxt = 1'b0;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end

      S_ALLOC: begin
        if (pipe_vld_r) begin
          if (!rd_q.active && !rd_q.retired && rd_q.word.gen != GEN_MAX) begin
            fin          = 1'b1;
            wr.mem_en    = 1'b1;
            wr.set_act   = 1'b1;
            wr.word.key  = key_r;
            wr.word.pgen = pgen_r;
            wr.word.gen  = gen_inc;
            out_ok_nxt   = 1'b1;
            out_tok_nxt  = make_token(pipe_slot, gen_inc);
          end else begin
            // worn-out free slot stays retired even if the acquire fails
            wr.set_ret = !rd_q.active && !rd_q.retired;
            fin        = (pipe_idx_r == LAST_IDX);
          end
        end
      end

      S_TOKEN: begin
        if (pipe_vld_r) begin
          fin = 1'b1;
          if (req_r == REQ_CHECK) begin
            if (tok_ok) begin
              out_ok_nxt  = 1'b1;
              out_gen_nxt = rd_q.word.gen;
            end
          end else if (tok_ok && rd_q.word.pgen == pgen_r) begin
            out_ok_nxt  = 1'b1;
            out_key_nxt = rd_q.word.key;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt     = S_IDLE;
      issue_nxt     = 1'b0;
      pipe_vld_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    pgen_r     <= pgen_nxt;
    tgen_r     <= tgen_nxt;
    scan_r     <= scan_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    out_ok_r   <= out_ok_nxt;
    out_tok_r  <= out_tok_nxt;
    out_gen_r  <= out_gen_nxt;
    out_key_r  <= out_key_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_token_out      = out_tok_r;
  assign out_generation_out = out_gen_r;
  assign out_resolved_key   = out_key_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      out_token_out == '0 && out_generation_out == '0 && out_resolved_key == '0)
    else $error("failed transfer carries nonzero fields");

  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_source_key == '0 &&
    (in_req_type == REQ_FIND || in_req_type == REQ_ACQUIRE || in_req_type == REQ_RELEASE)
    |=> out_valid && !out_ok)
    else $error("zero key request did not fail at once");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_alloc_req: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> req_r == REQ_ACQUIRE)
    else $error("slot allocation scan outside an acquire");

endmodule

// ===== dv/generational_handle_table_unit_test.sv =====
`timescale 1ns / 1ps

module generational_handle_table_unit_test;
  import ght_pkg::*;

  localparam int SLOTS          = 64;
  localparam int RANDOM_ITEMS   = 600;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;

  typedef struct packed {
    logic             ok;
    logic [TOK_W-1:0] token;
    logic [GEN_W-1:0] gen;
    logic [KEY_W-1:0] key;
  } handle_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [KEY_W-1:0]  in_source_key = '0;
  logic [PGEN_W-1:0] in_package_gen = '0;
  logic [TOK_W-1:0]  in_token_in = '0;
  logic              out_valid;
  logic              out_ok;
  logic [TOK_W-1:0]  out_token_out;
  logic [GEN_W-1:0]  out_generation_out;
  logic [KEY_W-1:0]  out_resolved_key;

  generational_handle_table_unit #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_source_key     (in_source_key),
    .in_package_gen    (in_package_gen),
    .in_token_in       (in_token_in),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_token_out     (out_token_out),
    .out_generation_out(out_generation_out),
    .out_resolved_key  (out_resolved_key)
  );

  always #6 clk = ~clk;

  // shadow copy of the slot table
  logic              sh_active  [SLOTS] = '{default: 1'b0};
  logic              sh_retired [SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0]  sh_key     [SLOTS] = '{default: '0};
  logic [PGEN_W-1:0] sh_pgen    [SLOTS] = '{default: '0};
  logic [GEN_W-1:0]  sh_gen     [SLOTS] = '{default: '0};

  handle_reply_t pending_replies[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;

  function automatic int locate_key(logic [KEY_W-1:0] k);
    if (k == '0) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_active[i] && sh_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int valid_token_slot(logic [TOK_W-1:0] tk);
    int s;
    s = int'(tk[SLOT_W-1:0]) - 1;
    if (tk[SLOT_W-1:0] == '0 || s >= SLOTS) return -1;
    if (!sh_active[s] || tk[TOK_W-1:SLOT_W] == '0 || sh_gen[s] != tk[TOK_W-1:SLOT_W]) return -1;
    return s;
  endfunction

  function automatic logic [TOK_W-1:0] slot_token(int s);
    logic [SLOT_W-1:0] enc;
    enc = SLOT_W'(s + 1);
    return {sh_gen[s], enc};
  endfunction

  function automatic int active_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_active[i]) n++;
    end
    return n;
  endfunction

  function automatic int random_active_slot();
    int pick;
    if (active_slots() == 0) return -1;
    pick = $urandom_range(0, active_slots() - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_active[i]) begin
        if (pick == 0) return i;
        pick--;
      end
    end
    return -1;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    while (k == '0 || locate_key(k) >= 0) k = $urandom;
    return k;
  endfunction

  // Applies one accepted request to the shadow table and returns its reply.
  function automatic handle_reply_t apply_table_request(logic [REQ_W-1:0]  rt,
                                                        logic [KEY_W-1:0]  k,
                                                        logic [PGEN_W-1:0] pg,
                                                        logic [TOK_W-1:0]  tk);
    handle_reply_t r;
    int            s;
    logic          placed;
    r = '0;
    placed = 1'b0;
    case (rt)
      REQ_FIND: begin
        s = locate_key(k);
        if (s >= 0) begin
          r.ok = 1'b1;
          r.token = slot_token(s);
        end
      end
      REQ_ACQUIRE: begin
        s = locate_key(k);
        if (k == '0) begin
          r = '0;
        end else if (s >= 0) begin
          if (sh_pgen[s] == pg) begin
            r.ok = 1'b1;
            r.token = slot_token(s);
          end
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !sh_active[i] && !sh_retired[i]) begin
              // worn-out slot gets retired on the way, even if nothing is placed
              if (sh_gen[i] == GEN_MAX) begin
                sh_retired[i] = 1'b1;
              end else begin
                sh_active[i] = 1'b1;
                sh_key[i] = k;
                sh_pgen[i] = pg;
                sh_gen[i] = sh_gen[i] + 1'b1;
                r.ok = 1'b1;
                r.token = slot_token(i);
                placed = 1'b1;
              end
            end
          end
        end
      end
      REQ_RELEASE: begin
        s = locate_key(k);
        if (s >= 0) begin
          sh_active[s] = 1'b0;
          sh_key[s] = '0;
          sh_pgen[s] = '0;
          r.ok = 1'b1;
        end
      end
      REQ_CHECK: begin
        s = valid_token_slot(tk);
        if (s >= 0) begin
          r.ok = 1'b1;
          r.gen = sh_gen[s];
        end
      end
      REQ_RESOLVE: begin
        s = valid_token_slot(tk);
        if (s >= 0 && sh_pgen[s] == pg) begin
          r.ok = 1'b1;
          r.key = sh_key[s];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [REQ_W-1:0] rt, logic [KEY_W-1:0] k,
                              logic [PGEN_W-1:0] pg, logic [TOK_W-1:0] tk);
    int gap;
    in_req_type <= rt;
    in_source_key <= k;
    in_package_gen <= pg;
    in_token_in <= tk;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_replies.push_back(apply_table_request(rt, k, pg, tk));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TOK_W-1:0] pick_token(int s);
    int                idx;
    logic [SLOT_W-1:0] enc;
    idx = (s >= 0) ? s : $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return (s >= 0) ? slot_token(s) : TOK_W'($urandom);
      6: begin
        enc = SLOT_W'(idx + 1);
        return {sh_gen[idx] - 1'b1, enc};
      end
      7: return TOK_W'($urandom);
      8: return {GEN_W'($urandom), SLOT_W'(0)};
      default: return {GEN_W'($urandom), SLOT_W'($urandom_range(SLOTS + 1, 127))};
    endcase
  endfunction

  task automatic test_rejects_and_bad_tokens();
    send_request(REQ_FIND, '0, '0, '0);
    send_request(REQ_ACQUIRE, '0, '1, '0);
    send_request(REQ_RELEASE, '0, '0, '0);
    send_request(REQ_CHECK, '1, '0, '0);
    send_request(REQ_RESOLVE, '1, '0, '0);
    // slot field zero, generation bits set
    send_request(REQ_CHECK, '0, '0, 16'hFF80);
    send_request(REQ_RESOLVE, '0, '1, 16'hFF80);
    // slot field one past the table, and all ones
    send_request(REQ_CHECK, '0, '0, 16'h00C1);
    send_request(REQ_RESOLVE, '0, '0, 16'hFFFF);
    wait_for_replies();
  endtask

  task automatic test_slot_lifecycle();
    logic [TOK_W-1:0] stale;
    send_request(REQ_ACQUIRE, '1, '1, '0);
    send_request(REQ_ACQUIRE, '1, '1, '0);
    send_request(REQ_ACQUIRE, '1, '0, '0);
    send_request(REQ_FIND, '1, '0, '0);
    send_request(REQ_FIND, 32'h1, '0, '0);
    send_request(REQ_ACQUIRE, 32'h1, '0, '0);
    send_request(REQ_CHECK, '0, '0, slot_token(0));
    send_request(REQ_CHECK, '0, '0, slot_token(0) ^ 16'h0080);
    send_request(REQ_RESOLVE, '0, '1, slot_token(0));
    send_request(REQ_RESOLVE, '0, '0, slot_token(0));
    stale = slot_token(0);
    send_request(REQ_RELEASE, '1, '0, '0);
    send_request(REQ_RELEASE, '1, '0, '0);
    send_request(REQ_CHECK, '0, '0, stale);
    send_request(REQ_ACQUIRE, 32'h2, 16'h1234, '0);
    send_request(REQ_FIND, 32'h2, '0, '0);
    wait_for_replies();
  endtask

  task automatic test_unknown_requests();
    for (int u = REQ_RESOLVE + 1; u < (1 << REQ_W); u++) begin
      send_request(REQ_W'(u), 32'h2, 16'h1234, slot_token(0));
    end
    wait_for_replies();
  endtask

  // Fill the table, then wear slot 0 out while every other slot is held, so
  // the retiring scan ends with no slot granted.
  task automatic test_fill_and_retire();
    logic [KEY_W-1:0] k;
    logic [TOK_W-1:0] stale;
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_active[i]) send_request(REQ_RELEASE, sh_key[i], PGEN_W'($urandom), '0);
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_request(REQ_ACQUIRE, fresh_key(), PGEN_W'($urandom), TOK_W'($urandom));
    end
    send_request(REQ_ACQUIRE, fresh_key(), PGEN_W'($urandom), '0);
    send_request(REQ_RELEASE, sh_key[0], '0, '0);
    while (sh_gen[0] != GEN_MAX) begin
      k = fresh_key();
      send_request(REQ_ACQUIRE, k, PGEN_W'($urandom), TOK_W'($urandom));
      if ($urandom_range(0, 3) == 0) send_request(REQ_CHECK, k, '0, slot_token(0));
      if ($urandom_range(0, 7) == 0) send_request(REQ_RESOLVE, '0, sh_pgen[0], slot_token(0));
      stale = slot_token(0);
      send_request(REQ_RELEASE, k, PGEN_W'($urandom), '0);
      if ($urandom_range(0, 7) == 0) send_request(REQ_CHECK, '0, '0, stale);
    end
    send_request(REQ_ACQUIRE, fresh_key(), PGEN_W'($urandom), '0);
    send_request(REQ_ACQUIRE, fresh_key(), PGEN_W'($urandom), '0);
    send_request(REQ_RELEASE, sh_key[5], '0, '0);
    send_request(REQ_ACQUIRE, fresh_key(), PGEN_W'($urandom), '0);
    send_request(REQ_CHECK, '0, '0, {GEN_MAX, SLOT_W'(1)});
    wait_for_replies();
  endtask

  task automatic test_random_traffic();
    int                s;
    int                r;
    int                acq_w;
    logic [REQ_W-1:0]  rt;
    logic [KEY_W-1:0]  k;
    logic [PGEN_W-1:0] pg;
    logic [TOK_W-1:0]  tk;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      s = random_active_slot();
      k = (s >= 0) ? sh_key[s] : $urandom;
      pg = (s >= 0 && $urandom_range(0, 1) == 1) ? sh_pgen[s] : PGEN_W'($urandom);
      tk = pick_token(s);
      acq_w = (active_slots() < 24) ? 40 : 15;
      r = $urandom_range(0, 99);
      if (r < acq_w) rt = REQ_ACQUIRE;
      else if (r < acq_w + 20) rt = REQ_RELEASE;
      else if (r < acq_w + 35) rt = REQ_FIND;
      else if (r < acq_w + 50) rt = REQ_CHECK;
      else if (r < 95) rt = REQ_RESOLVE;
      else rt = REQ_RESOLVE + REQ_W'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0: k = '0;
        1: k = $urandom;
        2, 3, 4, 5: if (rt == REQ_ACQUIRE) k = fresh_key();
        default: k = k;
      endcase
      send_request(rt, k, pg, tk);
      if (n == RANDOM_ITEMS / 2) wait_for_replies();
    end
    wait_for_replies();
  endtask

  always @(posedge clk) begin : reply_check
    handle_reply_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected reply transfer: ok=%b tok=%h gen=%h key=%h",
                     out_ok, out_token_out, out_generation_out, out_resolved_key);
        end else begin
          want = pending_replies.pop_front();
          if (out_ok !== want.ok || out_token_out !== want.token ||
              out_generation_out !== want.gen || out_resolved_key !== want.key) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("reply mismatch: expected ok=%b tok=%h gen=%h key=%h, got ok=%b tok=%h gen=%h key=%h",
                       want.ok, want.token, want.gen, want.key,
                       out_ok, out_token_out, out_generation_out, out_resolved_key);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rejects_and_bad_tokens();
    test_slot_lifecycle();
    test_unknown_requests();
    test_fill_and_retire();
    test_random_traffic();
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
